FILE: rtl/rstg_pkg.sv
package rstg_pkg;

    // Field and register widths.
    localparam int PHASE_W   = 17;
    localparam int RATE_W    = 17;
    localparam int TONE_W    = 16;
    localparam int PROD_W    = PHASE_W + TONE_W;
    localparam int SAMPLE_W  = 16;
    localparam int TIDX_W    = 8;
    localparam int MAG_W     = 15;
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ   = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd16000;
    localparam logic [TONE_W-1:0] TONE_RESET = 16'd2000;

    // Fixed-point constants for building the sine table (Q61).
    localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q61  = 64'h2000000000000000;
    localparam logic [63:0] SIN_BIAS = 64'd4096;
    localparam logic [MAG_W-1:0] MAG_FULL = 15'd32767;

    // Taylor series denominators (2k)(2k+1) for k = 1 to 14.
    localparam logic [63:0] TAYLOR_DIV [14] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    // Product of two Q61 values, truncated back to Q61.
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[124:61];
    endfunction

    // Truncated sine magnitude scaled by 32767 for a Q61 angle in the first quadrant.
    function automatic logic [MAG_W-1:0] sine_q61(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] v;
        x2  = mul_q61(x, x);
        t   = x;
        sum = x;
        for (int k = 1; k <= 14; k++)
        begin
            t = mul_q61(t, x2) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
            begin
                sum = sum - t;
            end
            else
            begin
                sum = sum + t;
            end
        end
        sum = sum + SIN_BIAS;
        if (sum > ONE_Q61)
        begin
            sum = ONE_Q61;
        end
        hi = {32'd0, sum[63:32]};
        lo = {32'd0, sum[31:0]};
        v  = (hi * 64'd32767 + ((lo * 64'd32767) >> 32)) >> 29;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return MAG_W'(v);
    endfunction

endpackage

FILE: rtl/rstg_divider.sv
module rstg_divider #(
    parameter int NUM_W      = 41,
    parameter int TABLE_SIZE = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rstg_pkg::div_cmd_t              cmd,
    input  logic [NUM_W-1:0]                dividend,
    input  logic [rstg_pkg::RATE_W-1:0]     divisor,
    output logic                            done,
    output logic [rstg_pkg::RATE_W-1:0]     remainder,
    output logic [$clog2(TABLE_SIZE)-1:0]   qmod
);
    import rstg_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W:0] MOD_N = (IDX_W + 1)'(TABLE_SIZE);

    logic [NUM_W-1:0]  shift_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [IDX_W-1:0]  qmod_reg;
    logic [STEP_W-1:0] count_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RATE_W:0]   trial;
    logic              ge;
    logic [RATE_W-1:0] rem_next;
    logic [IDX_W:0]    qdbl;
    logic [IDX_W-1:0]  qmod_next;

    // One restoring division step; the quotient bit is also folded into a
    // running remainder modulo the table size.
    always_comb
    begin
        trial    = {rem_reg, shift_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? RATE_W'(trial - {1'b0, divisor}) : trial[RATE_W-1:0];
        qdbl     = {qmod_reg, ge};
        qmod_next = (qdbl >= MOD_N) ? IDX_W'(qdbl - MOD_N) : qdbl[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                count_reg <= cmd.steps;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - STEP_W'(1);
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            qmod_reg  <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[NUM_W-2:0], 1'b0};
            rem_reg   <= rem_next;
            qmod_reg  <= qmod_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign qmod      = qmod_reg;

endmodule

FILE: rtl/rstg_sine_rom.sv
module rstg_sine_rom #(
    parameter int TABLE_SIZE = 256
) (
    input  logic                           clk,
    input  logic [$clog2(TABLE_SIZE)-1:0]  addr,
    output logic [rstg_pkg::MAG_W-1:0]     data
);
    import rstg_pkg::*;

    localparam logic [63:0] N64 = 64'(TABLE_SIZE);

    logic [MAG_W-1:0] rom_w [TABLE_SIZE];
    logic [MAG_W-1:0] data_reg;

    // Each entry is worked out at elaboration: the angle is folded into the
    // first quadrant, and the quadrant end points are exact.
    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_entry
        localparam logic [63:0] M0 = 64'(i);
        localparam logic [63:0] M1 = (2 * M0 > N64) ? N64 - M0 : M0;
        localparam logic [63:0] P0 = 2 * M1;
        localparam logic [63:0] P1 = (2 * P0 > N64) ? N64 - P0 : P0;
        localparam logic [63:0] X  = (PI_Q61 / N64) * P1 + ((PI_Q61 % N64) * P1) / N64;
        localparam logic [MAG_W-1:0] MAG = (P1 == 64'd0) ? '0 :
                                           ((2 * P1 == N64) ? MAG_FULL : sine_q61(X));
        assign rom_w[i] = MAG;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

FILE: rtl/rectified_sine_table_generator_unit.sv
// An accepted tick runs the wrap pass, the multiply, the scaled division and the table
// read before the sample request; NUM_W, the dividend width, is 33 + clog2(TABLE_SIZE).
// No new tick is taken until the sequencer is idle again, as both passes share the
// bit-serial divider. A tick of zero is taken and gives no sample.
// Reset (rst_n, asynchronous, active low) clears the phase, returns the rates to
// 16000 Hz and 2000 Hz and empties the output register.
module rectified_sine_table_generator_unit #(
    parameter int TABLE_SIZE = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rstg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rstg_pkg::RATE_W-1:0]          cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 tick,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rstg_pkg::SAMPLE_W-1:0] sample,
    output logic [rstg_pkg::TIDX_W-1:0]          table_index
);
    import rstg_pkg::*;

    // Index bits and the width of phase * tone * TABLE_SIZE, the dividend of the
    // second pass through the divider.
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int NUM_W = PROD_W + IDX_W;

    // The sequencer walks one request through two passes of the shared divider.
    // The first pass reduces the phase modulo the sample rate; the second
    // divides phase * tone * TABLE_SIZE by the rate, while the divider keeps the
    // quotient reduced modulo the table size so that the index comes out of it
    // directly. The two multiplies sit in states of their own so that each
    // product is registered before it is used.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_LOOKUP,
        ST_SEND
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        sample_next;
    logic [TIDX_W-1:0]          tidx_reg;
    logic [TIDX_W-1:0]          tidx_next;
    logic [RATE_W-1:0]          rate_reg;
    logic [TONE_W-1:0]          tone_reg;

    logic [RATE_W-1:0]          rate_eff;
    logic                       in_take;
    logic                       out_take;
    div_cmd_t                   div_cmd;
    logic [NUM_W-1:0]           div_dividend;
    logic                       div_done;
    logic [RATE_W-1:0]          div_rem;
    logic [IDX_W-1:0]           div_qmod;
    logic [MAG_W-1:0]           rom_data;

    // A zero sample rate behaves as a rate of one, which pins the phase and
    // the index at zero.
    assign rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    // The block takes a new request only when the sequencer is idle. A finished
    // sample waits in the output register, so a fresh tick can start while
    // the previous sample is still stalled downstream.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Configuration registers. They are to be written only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
            tone_reg <= TONE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_RATE: rate_reg <= cfg_wdata;
                REG_TONE_FREQ:   tone_reg <= cfg_wdata[TONE_W-1:0];
            endcase
        end
    end

    // Divider requests. The first pass takes the phase left aligned and runs
    // for PHASE_W steps; the second takes the scaled product and runs for
    // all NUM_W bits.
    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.steps = STEP_W'(PHASE_W);
        div_dividend  = {phase_reg, (NUM_W - PHASE_W)'(0)};
        case (state_reg)
            ST_IDLE:
            begin
                div_cmd.start = in_take && tick;
            end
            ST_SCALE:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(NUM_W);
                div_dividend  = NUM_W'(prod_reg) * NUM_W'(TABLE_SIZE);
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    rstg_divider #(
        .NUM_W      (NUM_W),
        .TABLE_SIZE (TABLE_SIZE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (rate_eff),
        .done      (div_done),
        .remainder (div_rem),
        .qmod      (div_qmod)
    );

    // The index stays on the divider's output until the next request starts,
    // so the table read can be held for as long as the output is stalled.
    rstg_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .clk  (clk),
        .addr (div_qmod),
        .data (rom_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        prod_next      = prod_reg;
        sample_next    = sample_reg;
        tidx_next      = tidx_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // A tick of zero is accepted and leaves everything as it was.
                if (in_take && tick)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (div_done)
                begin
                    phase_next = div_rem;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // The product uses the wrapped phase; the phase then steps on.
                prod_next  = PROD_W'(phase_reg) * PROD_W'(tone_reg);
                phase_next = phase_reg + PHASE_W'(1);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                // The sample is the table magnitude negated.
                if (!out_valid_reg || out_take)
                begin
                    sample_next    = SAMPLE_W'(0) - {1'b0, rom_data};
                    tidx_next      = TIDX_W'(div_qmod);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            tidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            sample_reg    <= sample_next;
            tidx_reg      <= tidx_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = $signed(sample_reg);
    assign table_index = tidx_reg;

endmodule

FILE: rtl/rstg_checker.sv
module rstg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               tick,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample,
    input logic [7:0]         table_index
);

    // A stalled sample request keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(table_index))
        else $error("stalled sample request changed");

    // Every sample is a negated magnitude.
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample <= 16'sd0) && (sample >= -16'sd32767))
        else $error("sample outside -32767..0");

    // A tick starts the sequencer, which then holds off further requests.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && tick |=> in_stall)
        else $error("block not busy after a tick");

    // A zero tick leaves the block idle.
    a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !tick |=> !in_stall)
        else $error("block busy after a zero tick");

    // A new sample appears only at the end of a busy stretch.
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("sample request without work");

endmodule

bind rectified_sine_table_generator_unit rstg_checker u_rstg_checker (.*);
